/* src/odps_pkg.sv */
package odps_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int SEL_W      = 5;
  localparam int CMP_W      = (CNT_W > SEL_W) ? CNT_W : SEL_W;

  localparam int PID_W   = 32;
  localparam int LSN_W   = 64;
  localparam int DIRTY_W = 20;
  localparam int REQ_W   = 2;

  localparam int IN_W     = 104;
  localparam int OUT_BITS = 1 + PID_W + LSN_W + LSN_W + DIRTY_W + SEL_W;
  localparam int OUT_W    = 192;
  localparam int OUT_PAD  = OUT_W - OUT_BITS;

  localparam int CFG_DW = 64;
  localparam int CFG_AW = 4;

  localparam logic [DIRTY_W-1:0] DIRTY_MAX   = '1;
  localparam logic [SEL_W-1:0]   MAX_SEL_RST = SEL_W'(16);

  localparam logic REG_OLD_LSN = 1'b0;
  localparam logic REG_MAX_SEL = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_BEGIN  = 2'd0,
    REQ_PAGE   = 2'd1,
    REQ_FINISH = 2'd2
  } req_t;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [LSN_W-1:0] lsn;
  } entry_t;

  typedef struct packed {
    logic scan_begin;
    logic page_upd;
    logic emit_start;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic emit_last;
  } sts_t;

endpackage

/* src/odps_regs.sv */
module odps_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [odps_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [odps_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [odps_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready,
  output logic [odps_pkg::LSN_W-1:0]   old_lsn,
  output logic [odps_pkg::SEL_W-1:0]   max_sel
);
  import odps_pkg::*;

  logic [LSN_W-1:0] old_lsn_r, old_lsn_nxt;
  logic [SEL_W-1:0] max_sel_r, max_sel_nxt;
  logic             wr_en;
  logic             reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_sel    = cfg_paddr[CFG_AW-1];

  always_comb begin
    old_lsn_nxt = old_lsn_r;
    max_sel_nxt = max_sel_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_OLD_LSN: old_lsn_nxt = cfg_pwdata[LSN_W-1:0];
        REG_MAX_SEL: max_sel_nxt = cfg_pwdata[SEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_OLD_LSN: cfg_prdata = CFG_DW'(old_lsn_r);
      REG_MAX_SEL: cfg_prdata = CFG_DW'(max_sel_r);
      default:     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_lsn_r <= '0;
      max_sel_r <= MAX_SEL_RST;
    end else begin
      old_lsn_r <= old_lsn_nxt;
      max_sel_r <= max_sel_nxt;
    end
  end

  assign old_lsn = old_lsn_r;
  assign max_sel = max_sel_r;

endmodule

/* src/odps_ctrl.sv */
module odps_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic [odps_pkg::REQ_W-1:0] in_tuser,
  output logic                       in_tready,
  input  odps_pkg::sts_t             sts,
  output odps_pkg::cmd_t             cmd
);
  import odps_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  req_t   req;

  assign req = req_t'(in_tuser);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (req)
            REQ_BEGIN:  cmd.scan_begin = 1'b1;
            REQ_PAGE:   cmd.page_upd   = 1'b1;
            REQ_FINISH: begin
              cmd.emit_start = 1'b1;
              state_nxt      = ST_EMIT;
            end
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* src/odps_dp.sv */
module odps_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  odps_pkg::cmd_t              cmd,
  output odps_pkg::sts_t              sts,
  input  logic [odps_pkg::PID_W-1:0]  page_id,
  input  logic [odps_pkg::LSN_W-1:0]  redo_lsn,
  input  logic                        is_dirty,
  input  logic                        is_dependent,
  input  logic [odps_pkg::LSN_W-1:0]  old_lsn,
  input  logic [odps_pkg::SEL_W-1:0]  max_sel,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [odps_pkg::OUT_W-1:0]  out_tdata,
  output logic                        out_tlast
);
  import odps_pkg::*;

  entry_t             cells_r   [LIST_DEPTH];
  entry_t             cells_nxt [LIST_DEPTH];
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [LSN_W-1:0]   lowest_r, lowest_nxt;
  logic [DIRTY_W-1:0] dirty_r, dirty_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_data_r;
  logic               out_last_r;

  logic [CMP_W-1:0]      ms_ext, cap_ext;
  logic [CNT_W-1:0]      cap, fill_t, fill_m1, emit_cnt, idx_p1;
  logic [LIST_DEPTH-1:0] lt, gt;
  logic                  full, last_lt, admit, ins;
  entry_t                new_e, rd_e;
  logic                  has_entry;

  assign ms_ext  = CMP_W'(max_sel);
  assign cap_ext = (ms_ext > CMP_W'(LIST_DEPTH)) ? CMP_W'(LIST_DEPTH) : ms_ext;
  assign cap     = cap_ext[CNT_W-1:0];
  assign fill_t  = (fill_r > cap) ? cap : fill_r;
  assign fill_m1 = fill_t - CNT_W'(1);
  assign new_e   = '{pid: page_id, lsn: redo_lsn};

  // compare row, one cell per list entry
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      lt[i] = cells_r[i].lsn > redo_lsn;
      if (CNT_W'(i) < fill_t) begin
        gt[i] = lt[i] || ((cells_r[i].lsn == redo_lsn) && (cells_r[i].pid < page_id));
      end else begin
        gt[i] = 1'b1;
      end
    end
  end

  assign full    = (fill_t >= cap);
  assign last_lt = (fill_t != '0) && lt[fill_m1[IDX_W-1:0]];
  assign admit   = is_dirty && !is_dependent && (redo_lsn <= old_lsn) && (cap != '0) &&
                   (!full || last_lt);
  assign ins     = cmd.page_upd && admit;

  // shift cells at and after the insertion point
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (!gt[i]) begin
        cells_nxt[i] = cells_r[i];
      end else if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
        cells_nxt[i] = cells_r[(i > 0) ? i - 1 : 0];
      end else begin
        cells_nxt[i] = new_e;
      end
    end
  end

  always_comb begin
    fill_nxt   = fill_r;
    lowest_nxt = lowest_r;
    dirty_nxt  = dirty_r;
    if (cmd.scan_begin) begin
      fill_nxt   = '0;
      lowest_nxt = redo_lsn;
      dirty_nxt  = '0;
    end else if (cmd.page_upd) begin
      fill_nxt = fill_t;
      if (ins && !full) begin
        fill_nxt = fill_t + CNT_W'(1);
      end
      if (is_dirty) begin
        if (redo_lsn < lowest_r) begin
          lowest_nxt = redo_lsn;
        end
        if (dirty_r != DIRTY_MAX) begin
          dirty_nxt = dirty_r + DIRTY_W'(1);
        end
      end
    end
  end

  // readout
  assign emit_cnt      = (fill_r == '0) ? CNT_W'(1) : fill_r;
  assign idx_p1        = idx_r + CNT_W'(1);
  assign sts.emit_last = (idx_p1 == emit_cnt);
  assign sts.out_free  = !out_valid_r || out_tready;
  assign rd_e          = cells_r[idx_r[IDX_W-1:0]];
  assign has_entry     = (fill_r != '0);

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.emit_start) begin
      idx_nxt = '0;
    end else if (cmd.emit_load) begin
      idx_nxt = idx_p1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      lowest_r    <= '1;
      dirty_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      lowest_r    <= lowest_nxt;
      dirty_r     <= dirty_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
        cells_r[i] <= cells_nxt[i];
      end
    end
    if (cmd.emit_load) begin
      out_data_r <= {{OUT_PAD{1'b0}}, SEL_W'(fill_r), dirty_r, lowest_r,
                     has_entry ? rd_e.lsn : LSN_W'(0),
                     has_entry ? rd_e.pid : PID_W'(0),
                     has_entry};
      out_last_r <= sts.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

/* src/oldest_dirty_page_selector.sv */
// channel  | ports                      | contents (lowest bit up)
// in       | in_tvalid/tready/tdata/user | tdata: page_id, redo_lsn, is_dirty, is_dependent;
//          |                            | tuser: req_type
// out      | out_tvalid/tready/tdata/last | tdata: has_entry, sel_page_id, sel_lsn,
//          |                            | lowest_redo_out, dirty_total, selected_count
// cfg      | cfg_psel..cfg_pready       | 0x0 old_lsn, 0x8 max_selected
//
// begin and page requests are taken while idle; a page is inserted by a row of
// compare-and-shift cells in the cycle it is accepted
// finish emits max(fill, 1) results, loaded one at a time through the
// single readout port of the list; no request is taken until the last result
// is loaded into the output register
// output stalls hold the output register and pause the readout
// synchronous reset clears counts, list fill and lowest redo (all ones)
module oldest_dirty_page_selector (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [odps_pkg::IN_W-1:0]   in_tdata,   // page_id, redo_lsn, is_dirty, is_dependent
  input  logic [odps_pkg::REQ_W-1:0]  in_tuser,   // req_type
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [odps_pkg::OUT_W-1:0]  out_tdata,  // has_entry, sel_page_id, sel_lsn,
                                                  // lowest_redo_out, dirty_total,
                                                  // selected_count
  output logic                        out_tlast,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [odps_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [odps_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [odps_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import odps_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [LSN_W-1:0] old_lsn;
  logic [SEL_W-1:0] max_sel;

  odps_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .old_lsn     (old_lsn),
    .max_sel     (max_sel)
  );

  odps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  odps_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .page_id      (in_tdata[31:0]),
    .redo_lsn     (in_tdata[95:32]),
    .is_dirty     (in_tdata[96]),
    .is_dependent (in_tdata[97]),
    .old_lsn      (old_lsn),
    .max_sel      (max_sel),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast)
  );

endmodule

/* src/odps_checker.sv */
module odps_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [odps_pkg::OUT_W-1:0]  out_tdata,
  input logic                        out_tlast
);
  import odps_pkg::*;

  logic             has_entry;
  logic [SEL_W-1:0] sel_count;

  assign has_entry = out_tdata[0];
  assign sel_count = out_tdata[185:181];

  // empty list gives a single result
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !has_entry |-> out_tlast)
    else $error("empty list result not marked last");

  a_entry_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && has_entry |-> sel_count != '0)
    else $error("list entry with zero count");

  // no request taken in the middle of a readout
  a_busy_readout: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("request taken during readout");

  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast && in_tready && !in_tvalid |=> in_tready)
    else $error("not ready after final result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind oldest_dirty_page_selector odps_checker u_odps_checker (.*);
